### rtl/core/config_pulse_sequencer_core_assert.svh
// Assertion macros for the pulse sequencer checker.
// Both expect clk and rst in the scope of use.
`ifndef CONFIG_PULSE_SEQUENCER_CORE_ASSERT_SVH
`define CONFIG_PULSE_SEQUENCER_CORE_ASSERT_SVH

`define CPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse sequencer assertion failed");

`define CPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse sequencer assertion failed");

`endif

### rtl/core/cps_pkg.sv
package cps_pkg;

  localparam int CMD_W   = 2;
  localparam int SPEED_W = 16;
  localparam int ARR_W   = 3;
  localparam int MODE_W  = 2;
  localparam int PULSE_W = 12;
  localparam int LEVEL_W = 4;
  localparam int HOLD_W  = 16;

  localparam logic [CMD_W-1:0] CMD_SPEED   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEUTRAL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ARRANGE = 2'd3;

  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PULSE = 2'd2;

  localparam logic [PULSE_W-1:0] PULSE_BRAKE = 12'd4000;
  localparam logic [PULSE_W-1:0] PULSE_COAST = 12'd3500;

  localparam logic [ARR_W-1:0]  ARR_COUNT  = 3'd5;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;
  localparam logic [HOLD_W-1:0] TICK_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [SPEED_W-1:0] speed;
    logic                      enabled;
    logic                      brake;
    logic [ARR_W-1:0]          arrangement;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]         drive_mode;
    logic signed [SPEED_W-1:0] speed_out;
    logic [PULSE_W-1:0]        pulse_us;
    logic                      accepted;
    logic [LEVEL_W-1:0]        queue_level;
  } result_t;

  function automatic logic [PULSE_W-1:0] arr_pulse(input logic [ARR_W-1:0] code);
    logic [PULSE_W-1:0] us;
    case (code)
      3'd0:    us = 12'd3000;
      3'd1:    us = 12'd3100;
      3'd2:    us = 12'd3200;
      3'd3:    us = 12'd3300;
      3'd4:    us = 12'd3700;
      default: us = '0;
    endcase
    return us;
  endfunction

endpackage

### rtl/core/cps_in_if.sv
interface cps_in_if import cps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [SPEED_W-1:0] speed;
  logic                      enabled;
  logic                      brake;
  logic [ARR_W-1:0]          arrangement;

  modport source (output valid, cmd, speed, enabled, brake, arrangement, input ready);
  modport sink (input valid, cmd, speed, enabled, brake, arrangement, output ready);
endinterface

### rtl/core/cps_out_if.sv
interface cps_out_if import cps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         drive_mode;
  logic signed [SPEED_W-1:0] speed_out;
  logic [PULSE_W-1:0]        pulse_us;
  logic                      accepted;
  logic [LEVEL_W-1:0]        queue_level;

  modport source (output valid, drive_mode, speed_out, pulse_us, accepted, queue_level,
                  input ready);
  modport sink (input valid, drive_mode, speed_out, pulse_us, accepted, queue_level,
                output ready);
endinterface

### rtl/core/config_pulse_sequencer_core.sv
// Configuration pulse sequencer core.
// req carries one item per handshake: a speed command, a timer tick, or a
// neutral-mode or arrangement request that queues a configuration pulse.
// rsp returns exactly one result item for every request item, in order.
// cfg_wr_en / cfg_wr_data write hold_ticks; write only while idle.
// An accepted item is registered into the work stage, and its result is
// registered into the result register, which drives rsp.
// Throughput: one item per cycle while rsp is taken, set by the single pass
// from the work stage through the queue and timer logic to the result
// register; the queue store has one write port and one registered read port.
// Reset (rst, synchronous): queue empty, timer stopped at zero, hold_ticks
// back to 100, both stages empty. No clearing pass is needed.
// Stall: while rsp is not taken the result register and the work stage hold,
// and req.ready drops once both are full.
module config_pulse_sequencer_core import cps_pkg::*; #(
  parameter int QUEUE_LIMIT = 11
) (
  input  logic              clk,
  input  logic              rst,
  cps_in_if.sink            req,
  cps_out_if.source         rsp,
  input  logic              cfg_wr_en,
  input  logic [HOLD_W-1:0] cfg_wr_data
);

  logic              stg_valid;
  item_t             stg_item;
  logic              out_valid;
  result_t           out_res;
  result_t           res;
  logic [HOLD_W-1:0] hold_ticks;
  logic              out_free;
  logic              adv;
  logic              take;

  assign out_free  = !out_valid || rsp.ready;
  assign adv       = stg_valid && out_free;
  assign req.ready = !stg_valid || adv;
  assign take      = req.valid && req.ready;

  cps_ctrl #(.QUEUE_LIMIT(QUEUE_LIMIT)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .item      (stg_item),
    .hold_ticks(hold_ticks),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid  <= 1'b0;
      out_valid  <= 1'b0;
      hold_ticks <= HOLD_RESET;
    end else begin
      stg_valid <= take || (stg_valid && !adv);
      if (out_free) begin
        out_valid <= adv;
      end
      if (cfg_wr_en) begin
        hold_ticks <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_item <= '{cmd: req.cmd, speed: req.speed, enabled: req.enabled,
                    brake: req.brake, arrangement: req.arrangement};
    end
    if (adv) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.drive_mode  = out_res.drive_mode;
  assign rsp.speed_out   = out_res.speed_out;
  assign rsp.pulse_us    = out_res.pulse_us;
  assign rsp.accepted    = out_res.accepted;
  assign rsp.queue_level = out_res.queue_level;

endmodule

### rtl/core/cps_queue.sv
module cps_queue import cps_pkg::*; #(
  parameter int QUEUE_LIMIT = 11,
  parameter int IDX_W = (QUEUE_LIMIT > 1) ? $clog2(QUEUE_LIMIT) : 1
) (
  input  logic               clk,
  input  logic               adv,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [PULSE_W-1:0] wdata,
  input  logic               pop,
  input  logic [IDX_W-1:0]   head,
  input  logic [IDX_W-1:0]   head_next,
  output logic [PULSE_W-1:0] head_val,
  output logic [PULSE_W-1:0] next_fwd
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_LIMIT - 1);

  logic [PULSE_W-1:0] mem [QUEUE_LIMIT];
  logic [PULSE_W-1:0] next_val;
  logic [IDX_W-1:0]   head_plus1;
  logic [IDX_W-1:0]   rd_addr;

  assign head_plus1 = (head == LAST_IDX) ? '0 : head + IDX_W'(1);
  assign rd_addr    = (head_next == LAST_IDX) ? '0 : head_next + IDX_W'(1);
  assign next_fwd   = (we && waddr == head_plus1) ? wdata : next_val;

  // keep head_val on the head entry and next_val on the one behind it
  always_ff @(posedge clk) begin
    if (adv) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (we && waddr == rd_addr) begin
        next_val <= wdata;
      end else begin
        next_val <= mem[rd_addr];
      end
      if (we && waddr == head_next) begin
        head_val <= wdata;
      end else if (pop) begin
        head_val <= next_fwd;
      end
    end
  end

endmodule

### rtl/core/cps_ctrl.sv
module cps_ctrl import cps_pkg::*; #(
  parameter int QUEUE_LIMIT = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  item_t             item,
  input  logic [HOLD_W-1:0] hold_ticks,
  output result_t           res
);

  localparam int IDX_W = (QUEUE_LIMIT > 1) ? $clog2(QUEUE_LIMIT) : 1;
  localparam int CNT_W = $clog2(QUEUE_LIMIT + 1);
  localparam logic [CNT_W-1:0] LIMIT_C  = CNT_W'(QUEUE_LIMIT);
  localparam logic [CNT_W:0]   LIMIT_S  = (CNT_W + 1)'(QUEUE_LIMIT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_LIMIT - 1);

  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic              timer_running;
  logic [HOLD_W-1:0] elapsed;

  logic [IDX_W-1:0]   head_next;
  logic [CNT_W-1:0]   count_next;
  logic               timer_running_next;
  logic [HOLD_W-1:0]  elapsed_next;

  logic               is_req;
  logic               code_ok;
  logic               push;
  logic [PULSE_W-1:0] wdata;
  logic [CNT_W:0]     wsum;
  logic [IDX_W-1:0]   waddr;
  logic [CNT_W-1:0]   count1;
  logic               do_speed;
  logic               en;
  logic signed [SPEED_W-1:0] spd;
  logic [IDX_W-1:0]   head_plus1;
  logic               pop;
  logic               go_drive;
  logic               go_pulse;
  logic [PULSE_W-1:0] head_val;
  logic [PULSE_W-1:0] next_fwd;

  cps_queue #(.QUEUE_LIMIT(QUEUE_LIMIT), .IDX_W(IDX_W)) u_queue (
    .clk      (clk),
    .adv      (adv),
    .we       (push),
    .waddr    (waddr),
    .wdata    (wdata),
    .pop      (pop),
    .head     (head),
    .head_next(head_next),
    .head_val (head_val),
    .next_fwd (next_fwd)
  );

  assign is_req  = (item.cmd == CMD_NEUTRAL) || (item.cmd == CMD_ARRANGE);
  assign code_ok = (item.cmd == CMD_NEUTRAL) || (item.arrangement < ARR_COUNT);
  assign push    = is_req && code_ok && (count < LIMIT_C);
  assign wdata   = (item.cmd == CMD_NEUTRAL) ? (item.brake ? PULSE_BRAKE : PULSE_COAST)
                                             : arr_pulse(item.arrangement);
  assign wsum    = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
  assign waddr   = (wsum >= LIMIT_S) ? IDX_W'(wsum - LIMIT_S) : IDX_W'(wsum);
  assign count1  = count + CNT_W'(push);

  assign do_speed   = (item.cmd == CMD_SPEED) || (push && item.enabled);
  assign en         = (item.cmd == CMD_SPEED) ? item.enabled : 1'b1;
  assign spd        = (item.cmd == CMD_SPEED) ? item.speed : '0;
  assign head_plus1 = (head == LAST_IDX) ? '0 : head + IDX_W'(1);

  always_comb begin
    pop                = 1'b0;
    go_drive           = 1'b0;
    go_pulse           = 1'b0;
    head_next          = head;
    count_next         = count1;
    timer_running_next = timer_running;
    elapsed_next       = elapsed;
    if (do_speed) begin
      if (!timer_running) begin
        if (!en || count1 == '0) begin
          go_drive = 1'b1;
        end else begin
          go_pulse = 1'b1;
        end
      end else if (!en) begin
        go_drive = 1'b1;
      end else if (elapsed > hold_ticks) begin
        if (count1 != '0) begin
          pop        = 1'b1;
          head_next  = head_plus1;
          count_next = count1 - CNT_W'(1);
        end
        if (count_next == '0) begin
          go_drive = 1'b1;
        end else begin
          go_pulse = 1'b1;
        end
      end
    end else if (item.cmd == CMD_TICK && timer_running && elapsed != TICK_MAX) begin
      elapsed_next = elapsed + HOLD_W'(1);
    end
    if (go_drive) begin
      timer_running_next = 1'b0;
    end
    if (go_pulse) begin
      timer_running_next = 1'b1;
      elapsed_next       = '0;
    end
  end

  always_comb begin
    res.drive_mode  = go_pulse ? MODE_PULSE : (go_drive ? MODE_DRIVE : MODE_NONE);
    res.speed_out   = go_drive ? spd : '0;
    if (!go_pulse) begin
      res.pulse_us = '0;
    end else if (pop) begin
      res.pulse_us = next_fwd;
    end else if (count == '0) begin
      res.pulse_us = wdata;
    end else begin
      res.pulse_us = head_val;
    end
    res.accepted    = push;
    res.queue_level = LEVEL_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      count         <= '0;
      timer_running <= 1'b0;
      elapsed       <= '0;
    end else if (adv) begin
      head          <= head_next;
      count         <= count_next;
      timer_running <= timer_running_next;
      elapsed       <= elapsed_next;
    end
  end

endmodule

### rtl/core/cps_checker.sv
`include "config_pulse_sequencer_core_assert.svh"

module cps_checker import cps_pkg::*; #(
  parameter int QUEUE_LIMIT = 11
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [MODE_W-1:0]         rsp_drive_mode,
  input logic signed [SPEED_W-1:0] rsp_speed_out,
  input logic [PULSE_W-1:0]        rsp_pulse_us,
  input logic [LEVEL_W-1:0]        rsp_queue_level
);

  `CPS_ASSERT_NEXT(a_hold_valid, rsp_valid && !rsp_ready, rsp_valid)
  `CPS_ASSERT_SAME(a_level_bound, rsp_valid, int'(rsp_queue_level) <= QUEUE_LIMIT)
  `CPS_ASSERT_SAME(a_pulse_zero, rsp_valid && rsp_drive_mode != MODE_PULSE, rsp_pulse_us == '0)
  `CPS_ASSERT_SAME(a_speed_zero, rsp_valid && rsp_drive_mode != MODE_DRIVE, rsp_speed_out == '0)

endmodule

bind config_pulse_sequencer_core cps_checker #(.QUEUE_LIMIT(QUEUE_LIMIT)) u_cps_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_drive_mode (rsp.drive_mode),
  .rsp_speed_out  (rsp.speed_out),
  .rsp_pulse_us   (rsp.pulse_us),
  .rsp_queue_level(rsp.queue_level)
);
